### rtl/rti_pkg.sv
// Package for the ray/triangle intersection core: widths, payload structs and
// the divider stage record. No dependencies; every RTL file imports it.
package rti_pkg;

    // Coordinate format and result format.
    localparam int COORD_WIDTH = 20;
    localparam int VEC_W       = 60;
    localparam int T_WIDTH     = 32;
    localparam int T_FRAC      = 16;
    localparam int T_SHIFT     = T_WIDTH - T_FRAC;
    localparam int THR_W       = 20;
    localparam logic [THR_W-1:0] THR_RESET = 20'd1074;

    // Operation codes of the opcode field.
    localparam logic OP_RAY     = 1'b0;
    localparam logic OP_SEGMENT = 1'b1;

    // Derived datapath widths.
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int LO_W    = CROSS_W / 2;
    localparam int HI_W    = CROSS_W - LO_W;
    localparam int PL_W    = DIFF_W + LO_W + 1;
    localparam int PH_W    = DIFF_W + HI_W;
    localparam int DOT_W   = DIFF_W + CROSS_W + 2;
    localparam int MAG_W   = DOT_W - 1;

    // Input beat.
    typedef struct packed {
        logic             opcode;
        logic [VEC_W-1:0] vertex_a;
        logic [VEC_W-1:0] vertex_b;
        logic [VEC_W-1:0] vertex_c;
        logic [VEC_W-1:0] ray_origin;
        logic [VEC_W-1:0] ray_direction_or_end;
    } t_rti_in;

    // Output beat.
    typedef struct packed {
        logic               hit;
        logic [T_WIDTH-1:0] distance;
        logic               distance_saturated;
    } t_rti_out;

    // One stage of the restoring divider; bits holds the numerator bits still
    // to be consumed at the top and the quotient bits collected at the bottom.
    typedef struct packed {
        logic               hit;
        logic               sat;
        logic [MAG_W-1:0]   den;
        logic [MAG_W-1:0]   rem;
        logic [T_WIDTH-1:0] bits;
    } t_rti_div;

endpackage

### rtl/rti_divider.sv
// Pipelined restoring divider for the intersection core, one quotient bit per
// stage. Depends on rti_pkg.
module rti_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  rti_pkg::t_rti_div i_data,
    output logic              o_valid,
    output rti_pkg::t_rti_div o_data
);
    import rti_pkg::*;

    // One shift-compare-subtract step.
    function automatic t_rti_div div_step(input t_rti_div x);
        t_rti_div   y;
        logic [MAG_W:0] trial;
        y     = x;
        trial = {x.rem, x.bits[T_WIDTH-1]};
        if (trial >= {1'b0, x.den}) begin
            y.rem  = MAG_W'(trial - {1'b0, x.den});
            y.bits = {x.bits[T_WIDTH-2:0], 1'b1};
        end else begin
            y.rem  = MAG_W'(trial);
            y.bits = {x.bits[T_WIDTH-2:0], 1'b0};
        end
        return y;
    endfunction

    t_rti_div r_stg [T_WIDTH];
    logic     r_vld [T_WIDTH];

    // First stage takes the beat from the decision stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
        if (i_en) begin
            r_stg[0] <= div_step(i_data);
        end
    end

    // Remaining stages, each one step further.
    for (genvar g = 1; g < T_WIDTH; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= r_vld[g-1];
            end
            if (i_en) begin
                r_stg[g] <= div_step(r_stg[g-1]);
            end
        end
    end

    assign o_valid = r_vld[T_WIDTH-1];
    assign o_data  = r_stg[T_WIDTH-1];

endmodule

### rtl/ray_triangle_intersect_core.sv
// Ray/triangle intersection core (Moller-Trumbore, exact fixed point), top level.
// Throughput: one beat per cycle; the whole pipeline advances together and
// holds when the output register is full and not taken.
// Reset: synchronous, active low; clears all valid bits, threshold becomes 1074.
// Depends on rti_pkg and rti_divider.
module ray_triangle_intersect_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  rti_pkg::t_rti_in      i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output rti_pkg::t_rti_out     o_out_data,
    input  logic                  i_cfg_we,
    input  logic [19:0]           i_cfg_wdata
);
    import rti_pkg::*;

    localparam int NPRE = 8;

    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [CROSS_W-1:0] t_cross;
    typedef logic signed [PL_W-1:0]    t_pl;
    typedef logic signed [PH_W-1:0]    t_ph;
    typedef logic signed [DOT_W-1:0]   t_dot;

    // Extract one signed coordinate, widened for the difference stage.
    function automatic t_diff coord(input logic [VEC_W-1:0] v, input int k);
        logic signed [COORD_WIDTH-1:0] c;
        c = v[k*COORD_WIDTH +: COORD_WIDTH];
        return DIFF_W'(c);
    endfunction

    logic             en;
    logic             r_vld [NPRE];
    logic [THR_W-1:0] r_thr;

    // Whole pipeline moves when the output register can take a beat.
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // Valid bits of the front stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NPRE; i++) r_vld[i] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int i = 1; i < NPRE; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    // Stage 1: edges, origin offset and direction.
    logic  r1_seg;
    t_diff r1_e1 [3], r1_e2 [3], r1_s [3], r1_d [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_seg <= i_in_data.opcode;
            for (int k = 0; k < 3; k++) begin
                r1_e1[k] <= coord(i_in_data.vertex_b, k) - coord(i_in_data.vertex_a, k);
                r1_e2[k] <= coord(i_in_data.vertex_c, k) - coord(i_in_data.vertex_a, k);
                r1_s[k]  <= coord(i_in_data.ray_origin, k) - coord(i_in_data.vertex_a, k);
                r1_d[k]  <= (i_in_data.opcode == OP_SEGMENT)
                    ? coord(i_in_data.ray_direction_or_end, k)
                      - coord(i_in_data.ray_origin, k)
                    : coord(i_in_data.ray_direction_or_end, k);
            end
        end
    end

    // Stage 2: products of both cross products (h = d x e2, q = s x e1).
    logic  r2_seg;
    t_diff r2_e1 [3], r2_e2 [3], r2_s [3], r2_d [3];
    t_prod r2_hp [3], r2_hn [3], r2_qp [3], r2_qn [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_seg <= r1_seg;
            for (int k = 0; k < 3; k++) begin
                r2_e1[k] <= r1_e1[k];
                r2_e2[k] <= r1_e2[k];
                r2_s[k]  <= r1_s[k];
                r2_d[k]  <= r1_d[k];
                r2_hp[k] <= r1_d[(k+1)%3] * r1_e2[(k+2)%3];
                r2_hn[k] <= r1_d[(k+2)%3] * r1_e2[(k+1)%3];
                r2_qp[k] <= r1_s[(k+1)%3] * r1_e1[(k+2)%3];
                r2_qn[k] <= r1_s[(k+2)%3] * r1_e1[(k+1)%3];
            end
        end
    end

    // Stage 3: cross product differences.
    logic   r3_seg;
    t_diff  r3_e1 [3], r3_e2 [3], r3_s [3], r3_d [3];
    t_cross r3_h [3], r3_q [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_seg <= r2_seg;
            for (int k = 0; k < 3; k++) begin
                r3_e1[k] <= r2_e1[k];
                r3_e2[k] <= r2_e2[k];
                r3_s[k]  <= r2_s[k];
                r3_d[k]  <= r2_d[k];
                r3_h[k]  <= CROSS_W'(r2_hp[k]) - CROSS_W'(r2_hn[k]);
                r3_q[k]  <= CROSS_W'(r2_qp[k]) - CROSS_W'(r2_qn[k]);
            end
        end
    end

    // Operand pairs of the four dot products: det, U, V and T.
    t_diff  opa [4][3];
    t_cross opb [4][3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            opa[0][k] = r3_e1[k]; opb[0][k] = r3_h[k];
            opa[1][k] = r3_s[k];  opb[1][k] = r3_h[k];
            opa[2][k] = r3_d[k];  opb[2][k] = r3_q[k];
            opa[3][k] = r3_e2[k]; opb[3][k] = r3_q[k];
        end
    end

    // Stage 4: each wide product split into low and high partial products.
    logic r4_seg;
    t_pl  r4_pl [4][3];
    t_ph  r4_ph [4][3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_seg <= r3_seg;
            for (int j = 0; j < 4; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r4_pl[j][k] <= opa[j][k]
                        * $signed({1'b0, opb[j][k][LO_W-1:0]});
                    r4_ph[j][k] <= opa[j][k]
                        * $signed(opb[j][k][CROSS_W-1:LO_W]);
                end
            end
        end
    end

    // Stage 5: recombine the partial products.
    logic r5_seg;
    t_dot r5_p [4][3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_seg <= r4_seg;
            for (int j = 0; j < 4; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r5_p[j][k] <= (DOT_W'(r4_ph[j][k]) <<< LO_W) + DOT_W'(r4_pl[j][k]);
                end
            end
        end
    end

    // Stage 6: sum the three terms of each dot product.
    logic r6_seg;
    t_dot r6_sum [4];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_seg <= r5_seg;
            for (int j = 0; j < 4; j++) begin
                r6_sum[j] <= r5_p[j][0] + r5_p[j][1] + r5_p[j][2];
            end
        end
    end

    // Stage 7: make the determinant positive, flipping the numerators with it.
    logic             r7_seg;
    logic [MAG_W-1:0] r7_det;
    t_dot             r7_n [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_seg <= r6_seg;
            r7_det <= MAG_W'(r6_sum[0][DOT_W-1] ? -r6_sum[0] : r6_sum[0]);
            for (int j = 0; j < 3; j++) begin
                r7_n[j] <= r6_sum[0][DOT_W-1] ? -r6_sum[j+1] : r6_sum[j+1];
            end
        end
    end

    // Stage 8: hit tests, saturation test and divider setup.
    t_dot                     det_s;
    logic signed [DOT_W:0]    uv_sum;
    logic [MAG_W-1:0]         tn_mag;
    logic [MAG_W+T_SHIFT-1:0] tn_wide, det_wide;
    logic                     pass;
    t_rti_div                 n8, r8;
    always_comb begin
        det_s    = $signed({1'b0, r7_det});
        uv_sum   = (DOT_W+1)'(r7_n[0]) + (DOT_W+1)'(r7_n[1]);
        tn_mag   = MAG_W'(r7_n[2]);
        tn_wide  = (MAG_W+T_SHIFT)'(tn_mag);
        det_wide = (MAG_W+T_SHIFT)'(r7_det) << T_SHIFT;
        pass = (r7_det != '0) && (r7_det >= MAG_W'(r_thr))
            && !r7_n[0][DOT_W-1] && !r7_n[1][DOT_W-1] && !r7_n[2][DOT_W-1]
            && (r7_n[0] <= det_s) && (uv_sum <= (DOT_W+1)'(det_s))
            && (!r7_seg || (r7_n[2] <= det_s));
        n8.hit  = pass;
        n8.sat  = tn_wide >= det_wide;
        n8.den  = r7_det;
        n8.rem  = MAG_W'(tn_mag >> T_SHIFT);
        n8.bits = T_WIDTH'(tn_mag) << T_FRAC;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8 <= n8;
        end
    end

    // Quotient t = T * 2^T_FRAC / det.
    logic     div_vld;
    t_rti_div div_out;
    rti_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vld[NPRE-1]),
        .i_data  (r8),
        .o_valid (div_vld),
        .o_data  (div_out)
    );

    // Output register: zero on a miss, all ones when saturated.
    logic     r_out_vld;
    t_rti_out r_out, n_out;
    always_comb begin
        n_out.hit                = div_out.hit;
        n_out.distance_saturated = div_out.hit && div_out.sat;
        if (!div_out.hit) begin
            n_out.distance = '0;
        end else if (div_out.sat) begin
            n_out.distance = '1;
        end else begin
            n_out.distance = div_out.bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= div_vld;
        end
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // A miss carries no distance and no saturation flag.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.hit
        |-> o_out_data.distance == '0 && !o_out_data.distance_saturated)
        else $error("miss with nonzero distance");

    // A saturated result is clamped to all ones.
    a_sat_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.distance_saturated
        |-> o_out_data.hit && o_out_data.distance == '1)
        else $error("saturated distance not clamped");

    // While the output is blocked, the front stages and the divider hold their beats.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld[0]) && $stable(r_vld[NPRE-1]) && $stable(div_vld))
        else $error("pipeline moved during stall");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

### bench/tb_ray_triangle_intersect_core.sv
// Self-checking testbench for ray_triangle_intersect_core: directed corner cases,
// then random triangle/ray pairs, checked beat by beat by a predictor.
// Depends on rti_pkg and the core's RTL; reads no files.
module tb_ray_triangle_intersect_core;
    timeunit 1ns;
    timeprecision 1ps;
    import rti_pkg::*;

    localparam int  LATENCY     = 41;
    localparam int  CYCLE_LIMIT = 600000;
    localparam int  RANDOM_N    = 2000;
    localparam int  ONE         = 1 << 10;  // 1.0 in Q10.10

    // Exact intersection predictor: numerators and determinant on wide integers.
    function automatic logic signed [127:0] dot3(input longint p[3],
                                                 input longint r[3]);
        logic signed [127:0] acc, pw, rw;
        acc = 0;
        for (int k = 0; k < 3; k++) begin
            pw = p[k];
            rw = r[k];
            acc += pw * rw;
        end
        return acc;
    endfunction

    function automatic void cross3(input longint p[3], input longint r[3],
                                   output longint x[3]);
        x[0] = p[1] * r[2] - p[2] * r[1];
        x[1] = p[2] * r[0] - p[0] * r[2];
        x[2] = p[0] * r[1] - p[1] * r[0];
    endfunction

    function automatic longint coord(input logic [VEC_W-1:0] v, input int k);
        logic signed [COORD_WIDTH-1:0] c;
        c = v[k*COORD_WIDTH +: COORD_WIDTH];
        return longint'(c);
    endfunction

    function automatic t_rti_out predict_intersection(input t_rti_in x,
                                                      input logic [THR_W-1:0] thr);
        longint a[3], b[3], c[3], o[3], d[3], e1[3], e2[3], s[3], h[3], q[3];
        logic signed [127:0] det, un, vn, tn, thr_w;
        logic [127:0] quo;
        t_rti_out r;
        r = '0;
        for (int k = 0; k < 3; k++) begin
            a[k] = coord(x.vertex_a, k);
            b[k] = coord(x.vertex_b, k);
            c[k] = coord(x.vertex_c, k);
            o[k] = coord(x.ray_origin, k);
            d[k] = coord(x.ray_direction_or_end, k);
            if (x.opcode == OP_SEGMENT) d[k] -= o[k];
            e1[k] = b[k] - a[k];
            e2[k] = c[k] - a[k];
            s[k] = o[k] - a[k];
        end
        cross3(d, e2, h);
        cross3(s, e1, q);
        det = dot3(e1, h);
        un = dot3(s, h);
        vn = dot3(d, q);
        tn = dot3(e2, q);
        if (det < 0) begin
            det = -det; un = -un; vn = -vn; tn = -tn;
        end
        thr_w = {108'd0, thr};
        if (det == 0 || det < thr_w) return r;
        if (un < 0 || vn < 0 || tn < 0) return r;
        if (un > det || un + vn > det) return r;
        if (x.opcode == OP_SEGMENT && tn > det) return r;
        quo = (128'(tn) << T_FRAC) / 128'(det);
        r.hit = 1'b1;
        if (quo > 128'({T_WIDTH{1'b1}})) begin
            r.distance = '1;
            r.distance_saturated = 1'b1;
        end else begin
            r.distance = quo[T_WIDTH-1:0];
        end
        return r;
    endfunction

    // Scoreboard: holds expected result beats in order of acceptance.
    class intersect_scoreboard;
        t_rti_out pending_q[$];
        int errors, hits, sats, items, results;

        function void note_input(t_rti_in x, logic [THR_W-1:0] thr);
            pending_q.push_back(predict_intersection(x, thr));
            items++;
        endfunction

        function void check_result(t_rti_out act);
            t_rti_out exp_r;
            results++;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: unexpected result beat %p", act);
                return;
            end
            exp_r = pending_q.pop_front();
            if (exp_r.hit) hits++;
            if (exp_r.distance_saturated) sats++;
            if (act.hit !== exp_r.hit || act.distance !== exp_r.distance ||
                act.distance_saturated !== exp_r.distance_saturated) begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: result %0d: expected hit=%0b dist=%h sat=%0b,",
                              " got hit=%0b dist=%h sat=%0b"},
                             results, exp_r.hit, exp_r.distance,
                             exp_r.distance_saturated,
                             act.hit, act.distance, act.distance_saturated);
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_in_valid = 1'b0;
    logic         o_in_ready;
    t_rti_in      i_in_data = '0;
    logic         o_out_valid;
    logic         i_out_ready = 1'b0;
    t_rti_out     o_out_data;
    logic         i_cfg_we = 1'b0;
    logic [19:0]  i_cfg_wdata = '0;

    intersect_scoreboard sb = new();
    logic [THR_W-1:0] threshold = THR_RESET;
    bit     gaps_on = 1'b1;
    int     cycles = 0;

    ray_triangle_intersect_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                     sb.pending_q.size());
            $display("** ray_triangle_intersect_core: FAILED **");
            $finish;
        end
    end

    // Receiver side: random stall bursts on ready.
    initial begin
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (gaps_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Output monitor; handshake values are stable at the falling edge.
    initial begin
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
        end
    end

    // Sends one input beat; valid stays high into the next call unless a gap comes.
    task automatic send_beat(input t_rti_in x);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= x;
        forever begin
            @(negedge i_clk);
            if (o_in_ready) break;
        end
        @(posedge i_clk);
        sb.note_input(x, threshold);
    endtask

    // Lets every expected result come back, then the pipeline settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        threshold = v;
    endtask

    function automatic logic [VEC_W-1:0] pack3(input longint x, input longint y,
                                               input longint z);
        return {z[COORD_WIDTH-1:0], y[COORD_WIDTH-1:0], x[COORD_WIDTH-1:0]};
    endfunction

    function automatic t_rti_in make_item(input bit op, input logic [VEC_W-1:0] a,
                                          input logic [VEC_W-1:0] b,
                                          input logic [VEC_W-1:0] c,
                                          input logic [VEC_W-1:0] o,
                                          input logic [VEC_W-1:0] d);
        t_rti_in x;
        x.opcode = op;
        x.vertex_a = a;
        x.vertex_b = b;
        x.vertex_c = c;
        x.ray_origin = o;
        x.ray_direction_or_end = d;
        return x;
    endfunction

    function automatic logic [VEC_W-1:0] rand_vec();
        return VEC_W'({$urandom(), $urandom()});
    endfunction

    function automatic longint rand_coord(input int mag_bits);
        longint m;
        m = longint'(1) << mag_bits;
        return longint'($urandom_range(0, 2 * m)) - m;
    endfunction

    // Well-formed pair: the ray's line goes through a point inside or on the triangle, at times reversed.
    function automatic t_rti_in aimed_item();
        longint a[3], b[3], c[3], o[3], p[3], d[3];
        int u, v, mb, sh, m;
        bit op, flip;
        mb = $urandom_range(4, 17);
        u = $urandom_range(0, 256);
        v = $urandom_range(0, 256 - u);
        op = 1'($urandom_range(0, 1));
        sh = $urandom_range(0, 4);
        m = $urandom_range(1, 8);
        flip = ($urandom_range(0, 7) == 0);
        for (int k = 0; k < 3; k++) begin
            a[k] = rand_coord(mb);
            b[k] = rand_coord(mb);
            c[k] = rand_coord(mb);
            o[k] = rand_coord(mb);
            p[k] = a[k] + (u * (b[k] - a[k]) + v * (c[k] - a[k])) / 256;
            d[k] = p[k] - o[k];
            if (flip) d[k] = -d[k];
            if (op == OP_SEGMENT) d[k] = o[k] + d[k] * m / 4;
            else d[k] = d[k] >>> sh;
        end
        return make_item(op, pack3(a[0], a[1], a[2]), pack3(b[0], b[1], b[2]),
                         pack3(c[0], c[1], c[2]), pack3(o[0], o[1], o[2]),
                         pack3(d[0], d[1], d[2]));
    endfunction

    // Mostly the unit triangle in the z = 0 plane, looked at along +z.
    task automatic directed_items();
        logic [VEC_W-1:0] ta, tb, tc, all1;
        ta = pack3(0, 0, 0);
        tb = pack3(ONE, 0, 0);
        tc = pack3(0, ONE, 0);
        all1 = '1;
        // Hits at the vertices and edges: u = v = 0, u = 1, v = 1, u + v = 1.
        send_beat(make_item(OP_RAY, ta, tb, tc, pack3(0, 0, -ONE), pack3(0, 0, ONE)));
        send_beat(make_item(OP_RAY, ta, tb, tc, pack3(ONE, 0, -ONE), pack3(0, 0, ONE)));
        send_beat(make_item(OP_RAY, ta, tb, tc, pack3(0, ONE, -ONE), pack3(0, 0, 2)));
        send_beat(make_item(OP_RAY, ta, tb, tc, pack3(ONE/2, ONE/2, -ONE),
                            pack3(0, 0, ONE)));
        // Just outside the hypotenuse and behind the origin.
        send_beat(make_item(OP_RAY, ta, tb, tc, pack3(ONE/2, ONE/2 + 1, -ONE),
                            pack3(0, 0, ONE)));
        send_beat(make_item(OP_RAY, ta, tb, tc, pack3(ONE/4, ONE/4, ONE),
                            pack3(0, 0, ONE)));
        // Origin on the plane: t = 0.
        send_beat(make_item(OP_RAY, ta, tb, tc, pack3(ONE/4, ONE/4, 0),
                            pack3(0, 0, -ONE)));
        // Segments ending exactly on the plane, and one short of it.
        send_beat(make_item(OP_SEGMENT, ta, tb, tc, pack3(ONE/4, ONE/4, -ONE),
                            pack3(ONE/4, ONE/4, 0)));
        send_beat(make_item(OP_SEGMENT, ta, tb, tc, pack3(ONE/4, ONE/4, -ONE),
                            pack3(ONE/4, ONE/4, -1)));
        // Direction in the plane: zero determinant.
        send_beat(make_item(OP_RAY, ta, tb, tc, pack3(0, 0, -ONE), pack3(ONE, 0, 0)));
        // Degenerate triangle.
        send_beat(make_item(OP_RAY, ta, ta, tc, pack3(0, 0, -ONE), pack3(0, 0, ONE)));
        // Tiny direction far away: t would saturate, but the point is just outside the hypotenuse: a miss.
        send_beat(make_item(OP_RAY, pack3(-(1 << 19), -(1 << 19), (1 << 19) - 1),
                            pack3((1 << 19) - 1, -(1 << 19), (1 << 19) - 1),
                            pack3(-(1 << 19), (1 << 19) - 1, (1 << 19) - 1),
                            pack3(0, 0, -(1 << 19)), pack3(0, 0, 1)));
        // Field extremes.
        send_beat(make_item(OP_SEGMENT, all1, all1, all1, all1, all1));
        send_beat(make_item(OP_RAY, '0, '0, '0, '0, '0));
        send_beat(make_item(OP_RAY, ta, pack3(-(1 << 19), 0, 0), pack3(0, (1 << 19) - 1, 0),
                            pack3(-1, 1, -(1 << 19)), pack3(0, 0, (1 << 19) - 1)));
    endtask

    initial begin
        int n;
        logic [THR_W-1:0] settings[4];
        t_rti_in x;
        settings[0] = THR_RESET;
        settings[1] = '0;
        settings[2] = '1;
        settings[3] = THR_W'($urandom_range(1, 4095));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset threshold first, then each setting in turn.
        directed_items();
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            write_threshold(settings[ph]);
            if (ph == 1) directed_items();
            n = (ph == 3) ? RANDOM_N - 3 * (RANDOM_N / 4) : RANDOM_N / 4;
            for (int i = 0; i < n; i++) begin
                if (ph == 3 && i >= n / 2) gaps_on = 1'b0;
                case ($urandom_range(0, 9))
                    0, 1: x = make_item(1'($urandom_range(0, 1)), rand_vec(), rand_vec(),
                                        rand_vec(), rand_vec(), rand_vec());
                    2: begin
                        x = aimed_item();
                        x.vertex_b = x.vertex_a;
                    end
                    default: x = aimed_item();
                endcase
                send_beat(x);
                // Sender holds off once mid-phase until everything is back.
                if (ph == 0 && i == n / 2) drain();
            end
            drain();
        end

        $display("Sent %0d beats over 4 threshold settings (reset, 0, max, random);",
                 sb.items);
        $display("%0d results checked, %0d hits, %0d with saturated distance.",
                 sb.results, sb.hits, sb.sats);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("** ray_triangle_intersect_core: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending_q.size());
            $display("** ray_triangle_intersect_core: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
rtl/rti_pkg.sv
rtl/rti_divider.sv
rtl/ray_triangle_intersect_core.sv
bench/tb_ray_triangle_intersect_core.sv
